// ===== rtl/bblc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bblc_pkg;
   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;
   localparam int FILE_W   = 32;
   localparam int OFF_W    = 40;
   localparam int HANDLE_W = 32;
   localparam int SIZE_W   = 21;
   localparam int CNT_W    = 48;
   localparam int USED_W   = 25;
   localparam int SUM_W    = 34;
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
   localparam logic [USED_W-1:0] USED_MAX = {USED_W{1'b1}};
   localparam logic [31:0] CAP_RESET = 32'd8388608;
endpackage
`default_nettype wire

// ===== rtl/byte_budget_lru_block_cache.sv =====
// flow: lookup, clear, OP_NONE, refresh and ignored inserts go from accept through S_EXEC to S_RESP (rsp_valid)
// an insert of a new key goes through S_EXEC, S_ADD and S_EVICT, which evicts entries over budget
// (at most ENTRIES-1; the full-table eviction is done in S_EXEC), then to S_RESP
// throughput: one beat at a time, next accept in S_IDLE after the response beat is taken; the
// subtract/compare unit of the eviction sequencer removes one oldest entry per cycle
// reset: synchronous; all entries invalid, counters and byte total zero, capacity 8388608
`timescale 1ns / 1ps
`default_nettype none
module byte_budget_lru_block_cache import bblc_pkg::*; #(
   parameter int ENTRIES = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [31:0]         csr_capacity_bytes,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_op,
   input  wire logic [FILE_W-1:0]   req_file_id,
   input  wire logic [OFF_W-1:0]    req_block_offset,
   input  wire logic                req_block_present,
   input  wire logic [HANDLE_W-1:0] req_block_handle,
   input  wire logic [SIZE_W-1:0]   req_block_size,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_hit,
   output logic [HANDLE_W-1:0]      rsp_found_handle,
   output logic [CNT_W-1:0]         rsp_hit_count,
   output logic [CNT_W-1:0]         rsp_miss_count,
   output logic [USED_W-1:0]        rsp_bytes_in_use
);
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_E_W = $clog2(ENTRIES + 1);

   typedef enum logic [2:0] {S_IDLE, S_EXEC, S_ADD, S_EVICT, S_RESP} state_type;

   state_type state_ff;
   logic [ENTRIES-1:0] valid_ff;
   logic [FILE_W-1:0] file_ff [ENTRIES];
   logic [OFF_W-1:0] off_ff [ENTRIES];
   logic [HANDLE_W-1:0] handle_ff [ENTRIES];
   logic [SIZE_W-1:0] bytes_ff [ENTRIES];
   logic [IDX_W-1:0] rank_ff [ENTRIES];
   logic [SUM_W-1:0] used_ff;
   logic [CNT_W-1:0] hits_ff, misses_ff;
   logic [31:0] cap_ff;
   logic [1:0] op_ff;
   logic [FILE_W-1:0] file_id_ff;
   logic [OFF_W-1:0] offset_ff;
   logic present_ff;
   logic [HANDLE_W-1:0] new_handle_ff;
   logic [SIZE_W-1:0] size_ff;
   logic hit_ff;
   logic [HANDLE_W-1:0] found_ff;
   logic [CNT_E_W-1:0] count_ff;

   // match and slot search over all entries
   logic [ENTRIES-1:0] match;
   logic any_match;
   logic [IDX_W-1:0] match_idx, free_idx, oldest_idx;
   logic [IDX_W-1:0] last_rank;
   always_comb begin
      any_match = 1'b0;
      match_idx = '0;
      free_idx = '0;
      oldest_idx = '0;
      last_rank = IDX_W'(count_ff - CNT_E_W'(1));
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         match[i] = valid_ff[i] && file_ff[i] == file_id_ff && off_ff[i] == offset_ff;
         if (match[i]) begin
            any_match = 1'b1;
            match_idx = IDX_W'(i);
         end
         if (!valid_ff[i])
            free_idx = IDX_W'(i);
         if (valid_ff[i] && rank_ff[i] == last_rank)
            oldest_idx = IDX_W'(i);
      end
   end

   logic [IDX_W-1:0] sel_rank;
   assign sel_rank = rank_ff[match_idx];
   logic evict_go;
   assign evict_go = used_ff > SUM_W'(cap_ff) && count_ff > CNT_E_W'(1);
   logic table_full;
   assign table_full = count_ff == CNT_E_W'(ENTRIES);

   assign req_ready = state_ff == S_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_valid = state_ff == S_RESP;
   assign rsp_hit = hit_ff;
   assign rsp_found_handle = found_ff;
   assign rsp_hit_count = hits_ff;
   assign rsp_miss_count = misses_ff;
   assign rsp_bytes_in_use = (used_ff > SUM_W'(USED_MAX)) ? USED_MAX : used_ff[USED_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         used_ff <= '0;
         hits_ff <= '0;
         misses_ff <= '0;
         cap_ff <= CAP_RESET;
         count_ff <= '0;
         hit_ff <= 1'b0;
         found_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) cap_ff <= csr_capacity_bytes;
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff <= req_op;
                  file_id_ff <= req_file_id;
                  offset_ff <= req_block_offset;
                  present_ff <= req_block_present;
                  new_handle_ff <= req_block_handle;
                  size_ff <= req_block_size;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               hit_ff <= 1'b0;
               found_ff <= '0;
               state_ff <= S_RESP;
               case (op_type'(op_ff))
                  OP_LOOKUP: begin
                     if (any_match) begin
                        if (hits_ff != CNT_MAX) hits_ff <= hits_ff + CNT_W'(1);
                        hit_ff <= 1'b1;
                        found_ff <= handle_ff[match_idx];
                        for (int i = 0; i < ENTRIES; i++)
                           if (valid_ff[i] && rank_ff[i] < sel_rank)
                              rank_ff[i] <= rank_ff[i] + IDX_W'(1);
                        rank_ff[match_idx] <= '0;
                     end else if (misses_ff != CNT_MAX) begin
                        misses_ff <= misses_ff + CNT_W'(1);
                     end
                  end
                  OP_INSERT: begin
                     if (cap_ff != '0 && present_ff) begin
                        if (any_match) begin
                           used_ff <= used_ff - SUM_W'(bytes_ff[match_idx]) + SUM_W'(size_ff);
                           handle_ff[match_idx] <= new_handle_ff;
                           bytes_ff[match_idx] <= size_ff;
                           for (int i = 0; i < ENTRIES; i++)
                              if (valid_ff[i] && rank_ff[i] < sel_rank)
                                 rank_ff[i] <= rank_ff[i] + IDX_W'(1);
                           rank_ff[match_idx] <= '0;
                        end else begin
                           if (table_full) begin
                              valid_ff[oldest_idx] <= 1'b0;
                              used_ff <= used_ff - SUM_W'(bytes_ff[oldest_idx]);
                              count_ff <= count_ff - CNT_E_W'(1);
                           end
                           state_ff <= S_ADD;
                        end
                     end
                  end
                  OP_CLEAR: begin
                     hits_ff <= '0;
                     misses_ff <= '0;
                  end
                  default: ;
               endcase
            end
            S_ADD: begin
               for (int i = 0; i < ENTRIES; i++)
                  if (valid_ff[i]) rank_ff[i] <= rank_ff[i] + IDX_W'(1);
               valid_ff[free_idx] <= 1'b1;
               file_ff[free_idx] <= file_id_ff;
               off_ff[free_idx] <= offset_ff;
               handle_ff[free_idx] <= new_handle_ff;
               bytes_ff[free_idx] <= size_ff;
               rank_ff[free_idx] <= '0;
               used_ff <= used_ff + SUM_W'(size_ff);
               count_ff <= count_ff + CNT_E_W'(1);
               state_ff <= S_EVICT;
            end
            S_EVICT: begin
               if (evict_go) begin
                  valid_ff[oldest_idx] <= 1'b0;
                  used_ff <= used_ff - SUM_W'(bytes_ff[oldest_idx]);
                  count_ff <= count_ff - CNT_E_W'(1);
               end else begin
                  state_ff <= S_RESP;
               end
            end
            S_RESP: begin
               if (rsp_ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_E_W'($countones(valid_ff)))
      else $error("entry count out of step with valid bits");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found_handle))
      else $error("response dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> op_ff == 2'(OP_LOOKUP))
      else $error("hit on non-lookup");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EVICT && evict_go |=> count_ff != '0)
      else $error("evicted last entry");
endmodule
`default_nettype wire
